// ----- src/albf_pkg.sv -----
// Package for the ambient light backlight fader: mode codes, register indexes, command
// codes, duty limits and register reset values. It depends on nothing else.
`default_nettype none

package albf_pkg;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_BURST  = 2'd1,
      MODE_FADE   = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      REG_CHANGE_THRESHOLD = 3'd0,
      REG_BURST_LENGTH     = 3'd1,
      REG_HITS_NEEDED      = 3'd2,
      REG_NORMAL_WAIT      = 3'd3,
      REG_BURST_WAIT       = 3'd4,
      REG_BRIGHTEN_WAIT    = 3'd5,
      REG_DARKEN_WAIT      = 3'd6
   } reg_index_type;

   typedef enum logic {
      CMD_READING = 1'b0,
      CMD_TICK    = 1'b1
   } command_type;

   localparam logic [6:0] DUTY_MIN = 7'd1;
   localparam logic [6:0] DUTY_MAX = 7'd100;

   localparam logic [6:0] RST_CHANGE_THRESHOLD = 7'd10;
   localparam logic [3:0] RST_BURST_LENGTH     = 4'd10;
   localparam logic [3:0] RST_HITS_NEEDED      = 4'd3;
   localparam logic [9:0] RST_NORMAL_WAIT      = 10'd100;
   localparam logic [9:0] RST_BURST_WAIT       = 10'd30;
   localparam logic [9:0] RST_BRIGHTEN_WAIT    = 10'd3;
   localparam logic [9:0] RST_DARKEN_WAIT      = 10'd10;

endpackage

`default_nettype wire

// ----- src/ambient_light_backlight_fader_core.sv -----
// Top level of the ambient light backlight fader: input register, state update and
// result register. It depends on albf_pkg.
`default_nettype none

// The block accepts one word per clock cycle unless the result side stalls, and returns
// one result word per input word, via the input and result registers. A word is held in
// an input register, and a single pass of compare, increment and select logic updates
// the fader state and loads the result register. Backpressure on the result side
// stalls the input register and then the input port. Configuration writes are taken
// in every cycle and should be made only while no words are in flight.
module ambient_light_backlight_fader_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [23:0] req_tdata,   // [16:0] light_reading, [23:17] zero
   input  wire logic [0:0]  req_tuser,   // [0] command
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [6:0] duty_level, [7] level_changed, [9:8] mode, [19:10] next_wait_ms, [23:20] zero
   output      logic [23:0] rsp_tdata,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [9:0]  csr_data
);

   logic [6:0] threshold_ff;
   logic [3:0] burst_length_ff;
   logic [3:0] hits_needed_ff;
   logic [9:0] normal_wait_ff;
   logic [9:0] burst_wait_ff;
   logic [9:0] brighten_wait_ff;
   logic [9:0] darken_wait_ff;

   logic        s1_valid_ff;
   logic        s1_cmd_ff;
   logic [16:0] s1_reading_ff;

   logic              out_valid_ff;
   logic [6:0]        out_level_ff;
   logic              out_changed_ff;
   albf_pkg::mode_type out_mode_ff;
   logic [9:0]        out_wait_ff;

   logic [6:0]         level_ff, level_in;
   albf_pkg::mode_type phase_ff, phase_in;
   logic [3:0]         burst_count_ff, burst_count_in;
   logic [3:0]         hit_count_ff, hit_count_in;
   logic [6:0]         target_ff, target_in;
   logic               changed_in;
   logic [9:0]         wait_in;

   logic       out_load;
   logic [6:0] duty;
   logic [6:0] diff;
   logic       band_out;
   logic [3:0] burst_inc;
   logic [3:0] hit_inc;
   logic [6:0] step_target;
   logic [6:0] step_level;
   logic       step_done;
   logic [9:0] step_wait;
   logic [9:0] fade_wait;

   assign csr_ready  = 1'b1;
   assign out_load   = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || out_load;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_wait_ff, out_mode_ff, out_changed_ff, out_level_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff     <= albf_pkg::RST_CHANGE_THRESHOLD;
         burst_length_ff  <= albf_pkg::RST_BURST_LENGTH;
         hits_needed_ff   <= albf_pkg::RST_HITS_NEEDED;
         normal_wait_ff   <= albf_pkg::RST_NORMAL_WAIT;
         burst_wait_ff    <= albf_pkg::RST_BURST_WAIT;
         brighten_wait_ff <= albf_pkg::RST_BRIGHTEN_WAIT;
         darken_wait_ff   <= albf_pkg::RST_DARKEN_WAIT;
      end else if (csr_valid && csr_ready) begin
         case (albf_pkg::reg_index_type'(csr_index))
            albf_pkg::REG_CHANGE_THRESHOLD: threshold_ff     <= csr_data[6:0];
            albf_pkg::REG_BURST_LENGTH:     burst_length_ff  <= csr_data[3:0];
            albf_pkg::REG_HITS_NEEDED:      hits_needed_ff   <= csr_data[3:0];
            albf_pkg::REG_NORMAL_WAIT:      normal_wait_ff   <= csr_data;
            albf_pkg::REG_BURST_WAIT:       burst_wait_ff    <= csr_data;
            albf_pkg::REG_BRIGHTEN_WAIT:    brighten_wait_ff <= csr_data;
            albf_pkg::REG_DARKEN_WAIT:      darken_wait_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         s1_cmd_ff     <= req_tuser[0];
         s1_reading_ff <= req_tdata[16:0];
      end
   end

   // A reading r in 1..100 maps to r itself, since 1 + floor(99r/100) equals r there.
   always_comb begin
      if (s1_reading_ff[16]) begin
         duty = albf_pkg::DUTY_MIN;
      end else if (s1_reading_ff[15:0] > 16'(albf_pkg::DUTY_MAX)) begin
         duty = albf_pkg::DUTY_MAX;
      end else if (s1_reading_ff[15:0] == 16'd0) begin
         duty = albf_pkg::DUTY_MIN;
      end else begin
         duty = s1_reading_ff[6:0];
      end
   end

   assign diff      = (duty > level_ff) ? (duty - level_ff) : (level_ff - duty);
   assign band_out  = diff > threshold_ff;
   assign burst_inc = burst_count_ff + 4'd1;
   assign hit_inc   = hit_count_ff + 4'd1;
   assign fade_wait = (target_ff > level_ff) ? brighten_wait_ff : darken_wait_ff;

   assign step_target = (phase_ff == albf_pkg::MODE_BURST) ? duty : target_ff;

   always_comb begin
      if (step_target > level_ff) begin
         step_level = level_ff + 7'd1;
      end else if (step_target < level_ff) begin
         step_level = level_ff - 7'd1;
      end else begin
         step_level = level_ff;
      end
      step_done = (step_level == step_target) || (step_level == albf_pkg::DUTY_MAX)
                  || (step_level == albf_pkg::DUTY_MIN);
      if (step_done) begin
         step_wait = normal_wait_ff;
      end else if (step_target > step_level) begin
         step_wait = brighten_wait_ff;
      end else begin
         step_wait = darken_wait_ff;
      end
   end

   always_comb begin
      level_in       = level_ff;
      phase_in       = phase_ff;
      burst_count_in = burst_count_ff;
      hit_count_in   = hit_count_ff;
      target_in      = target_ff;
      changed_in     = 1'b0;
      wait_in        = normal_wait_ff;
      if (s1_cmd_ff == albf_pkg::CMD_READING) begin
         case (phase_ff)
            albf_pkg::MODE_NORMAL: begin
               if (band_out) begin
                  phase_in       = albf_pkg::MODE_BURST;
                  burst_count_in = 4'd0;
                  hit_count_in   = 4'd0;
                  wait_in        = burst_wait_ff;
               end
            end
            albf_pkg::MODE_BURST: begin
               burst_count_in = burst_inc;
               if (band_out) begin
                  hit_count_in = hit_inc;
               end
               if (band_out && (hit_inc >= hits_needed_ff)) begin
                  target_in  = duty;
                  level_in   = step_level;
                  changed_in = 1'b1;
                  phase_in   = step_done ? albf_pkg::MODE_NORMAL : albf_pkg::MODE_FADE;
                  wait_in    = step_wait;
               end else if (burst_inc >= burst_length_ff) begin
                  phase_in = albf_pkg::MODE_NORMAL;
               end else begin
                  wait_in = burst_wait_ff;
               end
            end
            albf_pkg::MODE_FADE: begin
               wait_in = fade_wait;
            end
            default: ;
         endcase
      end else begin
         case (phase_ff)
            albf_pkg::MODE_FADE: begin
               level_in   = step_level;
               changed_in = 1'b1;
               phase_in   = step_done ? albf_pkg::MODE_NORMAL : albf_pkg::MODE_FADE;
               wait_in    = step_wait;
            end
            albf_pkg::MODE_BURST: begin
               wait_in = burst_wait_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff       <= albf_pkg::DUTY_MAX;
         phase_ff       <= albf_pkg::MODE_NORMAL;
         burst_count_ff <= 4'd0;
         hit_count_ff   <= 4'd0;
         target_ff      <= albf_pkg::DUTY_MAX;
      end else if (out_load) begin
         level_ff       <= level_in;
         phase_ff       <= phase_in;
         burst_count_ff <= burst_count_in;
         hit_count_ff   <= hit_count_in;
         target_ff      <= target_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (out_load) begin
         out_level_ff   <= level_in;
         out_changed_ff <= changed_in;
         out_mode_ff    <= phase_in;
         out_wait_ff    <= wait_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/albf_checker.sv -----
// Port checker for the ambient light backlight fader, bound to its top level.
// It depends on albf_pkg and ambient_light_backlight_fader_core.
`default_nettype none

module albf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[6:0] >= albf_pkg::DUTY_MIN)
                     && (rsp_tdata[6:0] <= albf_pkg::DUTY_MAX))
      else $error("Result word carries a duty level outside 1 to 100.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[7]) |-> (rsp_tdata[9:8] != albf_pkg::MODE_BURST))
      else $error("A level step was reported while in burst mode.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[9:8] == albf_pkg::MODE_BURST)) |-> !rsp_tdata[7])
      else $error("Burst mode result shows a changed level.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("Stalled result word was dropped or changed.");

endmodule

bind ambient_light_backlight_fader_core albf_checker u_albf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
